// ===== src/bsap_pkg.sv =====
// shared constants, codes and types of the bulk string array parser
`default_nettype none
package bsap_pkg;

  // default limits for the count and length fields
  localparam int unsigned MaxElementsDef = 255;
  localparam int unsigned MaxBulkLenDef  = 4095;

  // message length limit register
  localparam int unsigned    LenW          = 16;
  localparam logic [LenW-1:0] MaxLenReset  = 16'd1024;
  localparam logic [LenW-1:0] CountSat     = 16'hFFFF;

  // configuration port
  localparam int unsigned     CfgAddrW     = 1;
  localparam int unsigned     CfgDataW     = 32;
  localparam logic [CfgAddrW-1:0] CfgAddrMaxLen = 1'b0;

  // parse phases
  localparam int unsigned  PhaseW      = 4;
  localparam logic [PhaseW-1:0] PhStar    = 4'd0;
  localparam logic [PhaseW-1:0] PhCount   = 4'd1;
  localparam logic [PhaseW-1:0] PhCountLf = 4'd2;
  localparam logic [PhaseW-1:0] PhDollar  = 4'd3;
  localparam logic [PhaseW-1:0] PhLen     = 4'd4;
  localparam logic [PhaseW-1:0] PhLenLf   = 4'd5;
  localparam logic [PhaseW-1:0] PhPayload = 4'd6;
  localparam logic [PhaseW-1:0] PhPayCr   = 4'd7;
  localparam logic [PhaseW-1:0] PhPayLf   = 4'd8;
  localparam logic [PhaseW-1:0] PhError   = 4'd9;

  // error codes
  localparam logic [2:0] ErrBadStart   = 3'd0;
  localparam logic [2:0] ErrBadDigit   = 3'd1;
  localparam logic [2:0] ErrMissingLf  = 3'd2;
  localparam logic [2:0] ErrNoDollar   = 3'd3;
  localparam logic [2:0] ErrEmptyNum   = 3'd4;
  localparam logic [2:0] ErrBadTerm    = 3'd5;
  localparam logic [2:0] ErrTooLong    = 3'd6;
  localparam logic [2:0] ErrOverflow   = 3'd7;

  // framing characters
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // one result of the parser
  typedef struct packed {
    logic            payload_valid;
    logic [7:0]      payload_byte;
    logic            element_end;
    logic            message_done;
    logic            error_flag;
    logic [2:0]      error_code;
    logic [LenW-1:0] consumed_len;
  } res_t;

endpackage
`default_nettype wire

// ===== src/bsap_if.sv =====
// byte input and result channels of the parser
`default_nettype none
interface bsap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface bsap_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        element_end;
  logic        message_done;
  logic        error_flag;
  logic [2:0]  error_code;
  logic [15:0] consumed_len;

  modport source (output valid, payload_valid, payload_byte, element_end, message_done,
                  error_flag, error_code, consumed_len, input ready);
  modport sink   (input valid, payload_valid, payload_byte, element_end, message_done,
                  error_flag, error_code, consumed_len, output ready);
endinterface
`default_nettype wire

// ===== src/bsap_cfg.sv =====
// message length limit register behind the apb port
`default_nettype none
module bsap_cfg
  import bsap_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  output logic      [LenW-1:0]     max_len_o
);

  logic [LenW-1:0] max_len_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == CfgAddrMaxLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (wr_en) begin
      max_len_q <= pwdata[LenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CfgAddrMaxLen) begin
      prdata = {{(CfgDataW-LenW){1'b0}}, max_len_q};
    end
  end

  assign max_len_o = max_len_q;

endmodule
`default_nettype wire

// ===== src/bsap_step.sv =====
// next parse state and result for one byte
`default_nettype none
module bsap_step
  import bsap_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef,
  parameter int unsigned MaxBulkLen  = MaxBulkLenDef,
  localparam int unsigned ElemW = $clog2(MaxElements + 1),
  localparam int unsigned BulkW = $clog2(MaxBulkLen + 1),
  localparam int unsigned AccW  = (ElemW > BulkW) ? ElemW : BulkW
) (
  input  wire logic [PhaseW-1:0] phase_i,
  input  wire logic [ElemW-1:0]  elem_left_i,
  input  wire logic [BulkW-1:0]  pay_left_i,
  input  wire logic [AccW-1:0]   acc_i,
  input  wire logic              digit_seen_i,
  input  wire logic [LenW-1:0]   byte_cnt_i,
  input  wire logic [LenW-1:0]   max_len_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              restart_i,
  output logic      [PhaseW-1:0] phase_o,
  output logic      [ElemW-1:0]  elem_left_o,
  output logic      [BulkW-1:0]  pay_left_o,
  output logic      [AccW-1:0]   acc_o,
  output logic                   digit_seen_o,
  output logic      [LenW-1:0]   byte_cnt_o,
  output res_t                   res_o
);

  localparam int unsigned WideW = AccW + 4;
  localparam logic [WideW-1:0] ElemBound = WideW'(MaxElements);
  localparam logic [WideW-1:0] BulkBound = WideW'(MaxBulkLen);

  logic [PhaseW-1:0] ph;
  logic [ElemW-1:0]  el;
  logic [BulkW-1:0]  pl;
  logic [AccW-1:0]   acc;
  logic              ds;
  logic [LenW-1:0]   bc;
  logic              is_digit;
  logic [WideW-1:0]  acc_x10;
  logic              err;
  logic [2:0]        code;

  // restart abandons the message before this byte is looked at
  assign ph  = restart_i ? PhStar : phase_i;
  assign el  = restart_i ? '0 : elem_left_i;
  assign pl  = restart_i ? '0 : pay_left_i;
  assign acc = restart_i ? '0 : acc_i;
  assign ds  = restart_i ? 1'b0 : digit_seen_i;
  assign bc  = restart_i ? '0 : byte_cnt_i;

  assign is_digit = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
  // times ten as shift and add, then the digit
  assign acc_x10  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                  + {{(WideW-4){1'b0}}, data_byte_i[3:0]};

  always_comb begin
    logic [LenW-1:0] bc_s;
    phase_o      = ph;
    elem_left_o  = el;
    pay_left_o   = pl;
    acc_o        = acc;
    digit_seen_o = ds;
    byte_cnt_o   = bc;
    err          = 1'b0;
    code         = ErrBadStart;
    res_o        = '0;
    bc_s         = bc;

    if (ph != PhError) begin
      if (ph == PhStar) begin
        bc_s = '0;
      end
      if (bc_s >= max_len_i) begin
        err  = 1'b1;
        code = ErrTooLong;
      end else begin
        unique case (ph)
          PhStar: begin
            if (data_byte_i != ChStar) begin
              err  = 1'b1;
              code = ErrBadStart;
            end else begin
              acc_o        = '0;
              digit_seen_o = 1'b0;
              phase_o      = PhCount;
            end
          end
          PhCount: begin
            if (data_byte_i == ChCr) begin
              if (!ds) begin
                err  = 1'b1;
                code = ErrEmptyNum;
              end else begin
                elem_left_o = acc[ElemW-1:0];
                phase_o     = PhCountLf;
              end
            end else if (!is_digit) begin
              err  = 1'b1;
              code = ErrBadDigit;
            end else if (acc_x10 > ElemBound) begin
              err  = 1'b1;
              code = ErrOverflow;
            end else begin
              acc_o        = acc_x10[AccW-1:0];
              digit_seen_o = 1'b1;
            end
          end
          PhCountLf: begin
            if (data_byte_i != ChLf) begin
              err  = 1'b1;
              code = ErrMissingLf;
            end else if (el == '0) begin
              res_o.message_done = 1'b1;
              phase_o            = PhStar;
            end else begin
              phase_o = PhDollar;
            end
          end
          PhDollar: begin
            if (data_byte_i != ChDollar) begin
              err  = 1'b1;
              code = ErrNoDollar;
            end else begin
              acc_o        = '0;
              digit_seen_o = 1'b0;
              phase_o      = PhLen;
            end
          end
          PhLen: begin
            if (data_byte_i == ChCr) begin
              if (!ds) begin
                err  = 1'b1;
                code = ErrEmptyNum;
              end else begin
                pay_left_o = acc[BulkW-1:0];
                phase_o    = PhLenLf;
              end
            end else if (!is_digit) begin
              err  = 1'b1;
              code = ErrBadDigit;
            end else if (acc_x10 > BulkBound) begin
              err  = 1'b1;
              code = ErrOverflow;
            end else begin
              acc_o        = acc_x10[AccW-1:0];
              digit_seen_o = 1'b1;
            end
          end
          PhLenLf: begin
            if (data_byte_i != ChLf) begin
              err  = 1'b1;
              code = ErrMissingLf;
            end else begin
              phase_o = (pl != '0) ? PhPayload : PhPayCr;
            end
          end
          PhPayload: begin
            res_o.payload_valid = 1'b1;
            res_o.payload_byte  = data_byte_i;
            if (pl != '0) begin
              pay_left_o = pl - 1'b1;
            end
            if (pl <= BulkW'(1)) begin
              phase_o = PhPayCr;
            end
          end
          PhPayCr: begin
            if (data_byte_i != ChCr) begin
              err  = 1'b1;
              code = ErrBadTerm;
            end else begin
              phase_o = PhPayLf;
            end
          end
          PhPayLf: begin
            if (data_byte_i != ChLf) begin
              err  = 1'b1;
              code = ErrBadTerm;
            end else begin
              res_o.element_end = 1'b1;
              if (el != '0) begin
                elem_left_o = el - 1'b1;
              end
              if (el <= ElemW'(1)) begin
                res_o.message_done = 1'b1;
                phase_o            = PhStar;
              end else begin
                phase_o = PhDollar;
              end
            end
          end
          default: begin
            // codes with no phase behind them
            err  = 1'b1;
            code = ErrBadStart;
          end
        endcase
      end

      byte_cnt_o = (bc_s != CountSat) ? bc_s + 1'b1 : bc_s;

      if (err) begin
        phase_o = PhError;
        res_o   = '0;
      end
    end

    res_o.error_flag   = err;
    res_o.error_code   = err ? code : ErrBadStart;
    res_o.consumed_len = byte_cnt_o;
  end

endmodule
`default_nettype wire

// ===== src/bulk_string_array_parser.sv =====
// top level of the bulk string array parser
//
//  channel  | dir | payload                                          | transfer
//  ---------+-----+--------------------------------------------------+------------------
//  in_ch    | in  | data_byte, restart                               | valid && ready
//  out_ch   | out | payload_valid/byte, element_end, message_done,   | valid && ready
//           |     | error_flag, error_code, consumed_len             |
//  apb      | in  | max_message_len at address 0                     | psel&penable&pwrite
//
// one byte per cycle sustained while out_ch.ready stays high; after its transfer a byte's
// result passes the input register, then the parse step into the result register, and is
// offered on out_ch from the result register
// the parse state registers update when a byte moves from the input register to the result
// register, so a byte never waits on the state of the one before it
// out_ch.ready low holds the result register and then the input register; nothing is dropped
// asynchronous active-low reset clears the parse state and sets the limit to 1024
`default_nettype none
module bulk_string_array_parser
  import bsap_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElementsDef,
  parameter int unsigned MaxBulkLen  = MaxBulkLenDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  bsap_in_if.sink                  in_ch,
  bsap_out_if.source               out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready
);

  localparam int unsigned ElemW = $clog2(MaxElements + 1);
  localparam int unsigned BulkW = $clog2(MaxBulkLen + 1);
  localparam int unsigned AccW  = (ElemW > BulkW) ? ElemW : BulkW;

  // length limit register
  logic [LenW-1:0] max_len;

  bsap_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_restart_q;

  // result register
  logic res_valid_q;
  res_t res_q;

  // parse state
  logic [PhaseW-1:0] phase_q,      phase_d;
  logic [ElemW-1:0]  elem_left_q,  elem_left_d;
  logic [BulkW-1:0]  pay_left_q,   pay_left_d;
  logic [AccW-1:0]   acc_q,        acc_d;
  logic              digit_seen_q, digit_seen_d;
  logic [LenW-1:0]   byte_cnt_q,   byte_cnt_d;
  res_t              res_d;

  logic advance;
  logic in_xfer;

  // a byte moves on when the result register is empty or being emptied
  assign advance      = in_valid_q && (!res_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  bsap_step #(
    .MaxElements (MaxElements),
    .MaxBulkLen  (MaxBulkLen)
  ) u_step (
    .phase_i      (phase_q),
    .elem_left_i  (elem_left_q),
    .pay_left_i   (pay_left_q),
    .acc_i        (acc_q),
    .digit_seen_i (digit_seen_q),
    .byte_cnt_i   (byte_cnt_q),
    .max_len_i    (max_len),
    .data_byte_i  (in_byte_q),
    .restart_i    (in_restart_q),
    .phase_o      (phase_d),
    .elem_left_o  (elem_left_d),
    .pay_left_o   (pay_left_d),
    .acc_o        (acc_d),
    .digit_seen_o (digit_seen_d),
    .byte_cnt_o   (byte_cnt_d),
    .res_o        (res_d)
  );

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q    <= in_ch.data_byte;
      in_restart_q <= in_ch.restart;
    end
  end

  // parse state, updated once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStar;
      elem_left_q  <= '0;
      pay_left_q   <= '0;
      acc_q        <= '0;
      digit_seen_q <= 1'b0;
      byte_cnt_q   <= '0;
    end else if (advance) begin
      phase_q      <= phase_d;
      elem_left_q  <= elem_left_d;
      pay_left_q   <= pay_left_d;
      acc_q        <= acc_d;
      digit_seen_q <= digit_seen_d;
      byte_cnt_q   <= byte_cnt_d;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid         = res_valid_q;
  assign out_ch.payload_valid = res_q.payload_valid;
  assign out_ch.payload_byte  = res_q.payload_byte;
  assign out_ch.element_end   = res_q.element_end;
  assign out_ch.message_done  = res_q.message_done;
  assign out_ch.error_flag    = res_q.error_flag;
  assign out_ch.error_code    = res_q.error_code;
  assign out_ch.consumed_len  = res_q.consumed_len;

endmodule
`default_nettype wire

// ===== sim/bsap_checker.sv =====
// result checker of the bulk string array parser: predicts each result and compares it
`timescale 1ns / 100ps
module bsap_checker
  import bsap_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  bsap_in_if                       in_ch,
  bsap_out_if                      out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic                pready,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  input  wire logic [CfgDataW-1:0] prdata,
  output int                       mismatch_cnt_o,
  output int                       pending_cnt_o
);

  // predicted parser state
  logic [LenW-1:0]   msg_limit;
  logic [PhaseW-1:0] phase_q;
  logic [7:0]        elems_left;
  logic [11:0]       bytes_left;
  logic [11:0]       num_acc;
  logic              digit_seen;
  logic [LenW-1:0]   byte_cnt;

  res_t        expected_q[$];
  int unsigned result_idx;

  function automatic void clear_parse();
    phase_q    = PhStar;
    elems_left = '0;
    bytes_left = '0;
    num_acc    = '0;
    digit_seen = 1'b0;
    byte_cnt   = '0;
  endfunction

  // one parse step per byte transfer
  function automatic res_t parse_byte(input logic [7:0] b, input logic rs);
    res_t        r;
    logic        err;
    logic [2:0]  code;
    int unsigned limit_val;
    int unsigned acc_next;
    r    = '0;
    err  = 1'b0;
    code = ErrBadStart;
    if (rs) clear_parse();
    if (phase_q != PhError) begin
      if (phase_q == PhStar) byte_cnt = '0;
      if (byte_cnt >= msg_limit) begin
        err  = 1'b1;
        code = ErrTooLong;
      end else begin
        case (phase_q)
          PhStar: begin
            if (b != ChStar) begin
              err  = 1'b1;
              code = ErrBadStart;
            end else begin
              num_acc    = '0;
              digit_seen = 1'b0;
              phase_q    = PhCount;
            end
          end
          PhCount, PhLen: begin
            limit_val = (phase_q == PhCount) ? MaxElementsDef : MaxBulkLenDef;
            if (b == ChCr) begin
              if (!digit_seen) begin
                err  = 1'b1;
                code = ErrEmptyNum;
              end else if (phase_q == PhCount) begin
                elems_left = num_acc[7:0];
                phase_q    = PhCountLf;
              end else begin
                bytes_left = num_acc;
                phase_q    = PhLenLf;
              end
            end else if (b < ChZero || b > ChNine) begin
              err  = 1'b1;
              code = ErrBadDigit;
            end else begin
              acc_next = num_acc * 32'd10 + (b - ChZero);
              if (acc_next > limit_val) begin
                err  = 1'b1;
                code = ErrOverflow;
              end else begin
                num_acc    = acc_next[11:0];
                digit_seen = 1'b1;
              end
            end
          end
          PhCountLf: begin
            if (b != ChLf) begin
              err  = 1'b1;
              code = ErrMissingLf;
            end else if (elems_left == 0) begin
              r.message_done = 1'b1;
              phase_q        = PhStar;
            end else begin
              phase_q = PhDollar;
            end
          end
          PhDollar: begin
            if (b != ChDollar) begin
              err  = 1'b1;
              code = ErrNoDollar;
            end else begin
              num_acc    = '0;
              digit_seen = 1'b0;
              phase_q    = PhLen;
            end
          end
          PhLenLf: begin
            if (b != ChLf) begin
              err  = 1'b1;
              code = ErrMissingLf;
            end else begin
              phase_q = (bytes_left != 0) ? PhPayload : PhPayCr;
            end
          end
          PhPayload: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            if (bytes_left > 0) bytes_left--;
            if (bytes_left == 0) phase_q = PhPayCr;
          end
          PhPayCr: begin
            if (b != ChCr) begin
              err  = 1'b1;
              code = ErrBadTerm;
            end else begin
              phase_q = PhPayLf;
            end
          end
          PhPayLf: begin
            if (b != ChLf) begin
              err  = 1'b1;
              code = ErrBadTerm;
            end else begin
              r.element_end = 1'b1;
              if (elems_left > 0) elems_left--;
              if (elems_left == 0) begin
                r.message_done = 1'b1;
                phase_q        = PhStar;
              end else begin
                phase_q = PhDollar;
              end
            end
          end
          default: begin
            err  = 1'b1;
            code = ErrBadStart;
          end
        endcase
      end
      if (byte_cnt != CountSat) byte_cnt++;
      if (err) begin
        phase_q      = PhError;
        r            = '0;
        r.error_flag = 1'b1;
        r.error_code = code;
      end
    end
    r.consumed_len = byte_cnt;
    return r;
  endfunction

  // print is capped so a dead block cannot flood the log
  task automatic report_mismatch(input string what);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                result_idx, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      clear_parse();
      msg_limit = MaxLenReset;
      expected_q.delete();
      result_idx     = 0;
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
    end else begin
      if (psel && penable && pready && paddr == CfgAddrMaxLen) begin
        if (pwrite) begin
          msg_limit = pwdata[LenW-1:0];
        end else if (prdata[LenW-1:0] != msg_limit) begin
          report_mismatch($sformatf("limit read back 0x%0h, want 0x%0h",
                                    prdata[LenW-1:0], msg_limit));
        end
      end
      // compare before predicting: a byte never shows its result in its own cycle
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = expected_q.pop_front();
          check_field("payload_valid", out_ch.payload_valid, want.payload_valid);
          check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
          check_field("element_end", out_ch.element_end, want.element_end);
          check_field("message_done", out_ch.message_done, want.message_done);
          check_field("error_flag", out_ch.error_flag, want.error_flag);
          check_field("error_code", out_ch.error_code, want.error_code);
          check_field("consumed_len", out_ch.consumed_len, want.consumed_len);
        end
        result_idx++;
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(parse_byte(in_ch.data_byte, in_ch.restart));
      pending_cnt_o = expected_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// top of the parser testbench: clock, reset, byte stimulus, limit writes and verdict
`timescale 1ns / 100ps
module tb_top;
  import bsap_pkg::*;

  // far above the slowest correct run
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  bsap_in_if  in_ch ();
  bsap_out_if out_ch ();

  int          mismatch_cnt;
  int          pending_cnt;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_cnt;

  // bytes of the message being built or sent
  logic [7:0] msg_q[$];

  // run plan: length limit, sender idle and receiver stall in percent, random bytes
  // phase 0 and 4 hit the zero and one byte limits, phase 2 gets a small random limit
  int unsigned plan_limit [NumPhases] = '{0, 65535, 40, 1024, 1, 65535};
  int unsigned plan_idle  [NumPhases] = '{0, 0, 45, 0, 17, 17};
  int unsigned plan_stall [NumPhases] = '{0, 0, 0, 45, 17, 17};
  int unsigned plan_bytes [NumPhases] = '{12, 75, 75, 75, 15, 75};

  bulk_string_array_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bsap_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: ready changes only at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one byte transfer; called and returns just after a falling edge
  // valid stays high on return so back-to-back bytes leave no gap
  task automatic send_byte(input logic [7:0] b, input logic rs);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.restart   = rs;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // sends the whole queue, restart only on its first byte
  task automatic send_bytes(input logic rs_first);
    foreach (msg_q[i]) send_byte(msg_q[i], rs_first && i == 0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic push_crlf();
    msg_q.push_back(ChCr);
    msg_q.push_back(ChLf);
  endtask

  // decimal field, now and then with leading zeros
  task automatic push_number(input int unsigned val);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) msg_q.push_back(ChZero);
    push_text($sformatf("%0d", val));
  endtask

  // apb write of the length limit and a read back; called just after a falling edge
  // the upper data bits are random and must be ignored by the block
  task automatic cfg_limit(input logic [LenW-1:0] lim);
    psel               = 1'b1;
    penable            = 1'b0;
    pwrite             = 1'b1;
    paddr              = CfgAddrMaxLen;
    pwdata             = $urandom;
    pwdata[LenW-1:0]   = lim;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back setup; the checker compares prdata at the access cycle
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // drop valid and wait until every predicted result has come out
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one random message, mostly well formed with random content
  // broken is set when the parser is left mid-message or in error
  task automatic build_message(output bit broken);
    int unsigned sel;
    int unsigned count;
    int unsigned n_el;
    int unsigned len;
    int unsigned pos;
    broken = 1'b0;
    msg_q.delete();
    sel = $urandom_range(0, 99);
    // line noise
    if (sel < 5) begin
      repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
      broken = 1'b1;
      return;
    end
    msg_q.push_back(ChStar);
    sel = $urandom_range(0, 99);
    // count too big for the element limit
    if (sel < 5) begin
      push_number($urandom_range(MaxElementsDef + 1, 999));
      broken = 1'b1;
      return;
    end
    // count with no digits
    if (sel < 8) begin
      push_crlf();
      broken = 1'b1;
      return;
    end
    if (sel < 11)
      count = MaxElementsDef;
    else if (sel < 18)
      count = $urandom_range(5, MaxElementsDef - 1);
    else if (sel < 28)
      count = 0;
    else
      count = $urandom_range(1, 4);
    push_number(count);
    push_crlf();
    // large counts are cut short after two elements
    n_el = count;
    if (count > 4) begin
      n_el   = 2;
      broken = 1'b1;
    end
    repeat (n_el) begin
      msg_q.push_back(ChDollar);
      sel = $urandom_range(0, 99);
      // length over the bulk limit
      if (sel < 4) begin
        push_number($urandom_range(MaxBulkLenDef + 1, 9999));
        broken = 1'b1;
        return;
      end
      // length with no digits
      if (sel < 7) begin
        push_crlf();
        broken = 1'b1;
        return;
      end
      if (sel < 9)
        len = MaxBulkLenDef;
      else if (sel < 12)
        len = $urandom_range(31, MaxBulkLenDef - 1);
      else if (sel < 25)
        len = 0;
      else if (sel < 85)
        len = $urandom_range(1, 6);
      else
        len = $urandom_range(7, 30);
      push_number(len);
      push_crlf();
      // long payloads: only a few bytes, the next message restarts
      if (len > 30) begin
        repeat ($urandom_range(0, 5)) msg_q.push_back(8'($urandom));
        broken = 1'b1;
        return;
      end
      repeat (len) msg_q.push_back(8'($urandom));
      push_crlf();
    end
    // one corrupted byte or a cut in a quarter of the clean messages
    if (!broken && $urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, msg_q.size() - 1);
      sel = $urandom_range(0, 9);
      if (sel < 5)
        msg_q[pos] = 8'($urandom);
      else if (sel < 8)
        msg_q[pos] = ChZero + 8'($urandom_range(0, 9));
      else
        while (msg_q.size() > pos + 1) void'(msg_q.pop_back());
      broken = 1'b1;
    end
  endtask

  initial begin
    bit          broken;
    bit          need_restart;
    int unsigned sent;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = CfgAddrMaxLen;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.restart   = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    cycle_cnt       = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at the reset limit of 1024
    // zero count, then a message that starts right after it
    msg_q.delete();
    push_text("*0");
    push_crlf();
    // two elements: zero length, then the byte extremes as payload
    push_text("*2");
    push_crlf();
    push_text("$0");
    push_crlf();
    push_crlf();
    push_text("$2");
    push_crlf();
    msg_q.push_back(8'h00);
    msg_q.push_back(8'hFF);
    push_crlf();
    // bad start, then a byte that must be ignored
    msg_q.push_back(8'hFF);
    msg_q.push_back(ChStar);
    send_bytes(1'b0);
    // restart out of the error, then a count with no digits
    msg_q.delete();
    msg_q.push_back(ChStar);
    msg_q.push_back(ChCr);
    send_bytes(1'b1);
    need_restart = 1'b1;

    // random phases, each with its own limit and traffic pattern
    plan_limit[2] = $urandom_range(12, 60);
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      cfg_limit(plan_limit[p][LenW-1:0]);
      idle_pct  = plan_idle[p];
      stall_pct = plan_stall[p];
      sent      = 0;
      while (sent < plan_bytes[p]) begin
        build_message(broken);
        send_bytes(need_restart || $urandom_range(0, 9) == 0);
        // an over-long message leaves the parser in error as well
        need_restart = broken || (msg_q.size() > plan_limit[p]);
        sent += msg_q.size();
      end
    end

    wait_drained();
    repeat (16) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
